@@ design/cau_pkg.sv @@
// cau_pkg: operation codes shared by the complex arithmetic unit and its request interface
// no dependencies
package cau_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_t;

  localparam int unsigned OP_BITS = 3;

endpackage

@@ design/cau_if.sv @@
// cau_req_if / cau_rsp_if: valid/ready channels of the complex arithmetic unit
// depends on cau_pkg for the opcode width
interface cau_req_if #(parameter int DATA_WIDTH = 32);
  import cau_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [OP_BITS-1:0]           req_type;
  logic signed [DATA_WIDTH-1:0] a_re;
  logic signed [DATA_WIDTH-1:0] a_im;
  logic signed [DATA_WIDTH-1:0] b_re;
  logic signed [DATA_WIDTH-1:0] b_im;

  modport source (output valid, req_type, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, req_type, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] res_re;
  logic signed [DATA_WIDTH-1:0] res_im;
  logic                         is_equal;
  logic                         div_zero;
  logic                         overflowed;

  modport source (output valid, res_re, res_im, is_equal, div_zero, overflowed,
                  input ready);
  modport sink   (input valid, res_re, res_im, is_equal, div_zero, overflowed,
                  output ready);
endinterface

@@ design/complex_arith_unit.sv @@
// complex_arith_unit: pipelined complex add/sub/mul/div/compare on signed fixed point
// depends on cau_pkg and the channel interfaces in cau_if.sv
//
//  channel | dir | payload
//  --------+-----+--------------------------------------------------
//  req     | in  | req_type, a_re, a_im, b_re, b_im
//  rsp     | out | res_re, res_im, is_equal, div_zero, overflowed
//
// one item per cycle while the output is not stalled; the restoring divider
// resolves one quotient bit per stage
// rst clears all valid bits; payload registers are not reset
// the whole pipeline advances when the output register is empty or taken,
// so req.ready follows rsp.ready and an occupied output alone
module complex_arith_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic           clk,
  input  logic           rst,
  cau_req_if.sink        req,
  cau_rsp_if.source      rsp
);
  import cau_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W;        // product width
  localparam int SW  = 2 * W + 1;    // sum of products
  localparam int DW  = 2 * W;        // |b|^2
  localparam int NNW = SW + F;       // scaled numerator
  localparam int XW  = NNW + W;      // overflow precheck compare
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  function automatic logic [W:0] sat_fn(input logic signed [SW-1:0] x);
    logic fits;
    fits = (x[SW-1:W-1] == {(SW-W+1){x[SW-1]}});
    if (fits) return {1'b0, x[W-1:0]};
    else return {1'b1, x[SW-1] ? MINV : MAXV};
  endfunction

  logic adv;
  logic ovld;
  assign adv       = !ovld || rsp.ready;
  assign req.ready = adv;

  // stage 1: operand registers
  logic                v1;
  logic [OP_BITS-1:0]  op1;
  logic signed [W-1:0] ar1, ai1, br1, bi1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= req.valid;
    end
    if (adv) begin
      op1 <= req.req_type;
      ar1 <= req.a_re;
      ai1 <= req.a_im;
      br1 <= req.b_re;
      bi1 <= req.b_im;
    end
  end

  // stage 2: products, add/sub, equality
  logic                 v2, eq2;
  logic [OP_BITS-1:0]   op2;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, p_bb, p_dd;
  logic signed [W:0]    as_re2, as_im2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      op2  <= op1;
      p_rr <= ar1 * br1;
      p_ii <= ai1 * bi1;
      p_ri <= ar1 * bi1;
      p_ir <= ai1 * br1;
      p_bb <= br1 * br1;
      p_dd <= bi1 * bi1;
      if (op1 == OP_SUB) begin
        as_re2 <= (W+1)'(ar1) - (W+1)'(br1);
        as_im2 <= (W+1)'(ai1) - (W+1)'(bi1);
      end else begin
        as_re2 <= (W+1)'(ar1) + (W+1)'(br1);
        as_im2 <= (W+1)'(ai1) + (W+1)'(bi1);
      end
      eq2 <= (ar1 == br1) && (ai1 == bi1);
    end
  end

  // stage 3: sums of products and divisor magnitude
  logic                 v3, eq3;
  logic [OP_BITS-1:0]   op3;
  logic signed [SW-1:0] s_re3, s_im3;
  logic [DW-1:0]        den3;
  logic signed [W:0]    as_re3, as_im3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      op3    <= op2;
      eq3    <= eq2;
      as_re3 <= as_re2;
      as_im3 <= as_im2;
      den3   <= DW'($unsigned(p_bb)) + DW'($unsigned(p_dd));
      if (op2 == OP_MUL) begin
        s_re3 <= SW'(p_rr) - SW'(p_ii);
        s_im3 <= SW'(p_ri) + SW'(p_ir);
      end else begin
        s_re3 <= SW'(p_rr) + SW'(p_ii);
        s_im3 <= SW'(p_ir) - SW'(p_ri);
      end
    end
  end

  // stage 4 combinational: finish non-divide ops, prepare the divider
  logic [W:0]     sat_re, sat_im;
  logic [W-1:0]   f_re, f_im;
  logic           f_eq, f_ov;
  logic           n_re, n_im;
  logic [SW-1:0]  m_re, m_im;
  logic [NNW-1:0] nn_re, nn_im;
  logic           pov;

  always_comb begin
    sat_re = '0;
    sat_im = '0;
    f_eq   = 1'b0;
    case (op3)
      OP_ADD, OP_SUB: begin
        sat_re = sat_fn(SW'(as_re3));
        sat_im = sat_fn(SW'(as_im3));
      end
      OP_MUL: begin
        sat_re = sat_fn(s_re3 >>> F);
        sat_im = sat_fn(s_im3 >>> F);
      end
      OP_CMP: f_eq = eq3;
      default: ;
    endcase
    f_re = sat_re[W-1:0];
    f_im = sat_im[W-1:0];
    f_ov = sat_re[W] | sat_im[W];

    n_re  = s_re3[SW-1];
    n_im  = s_im3[SW-1];
    m_re  = n_re ? $unsigned(-s_re3) : $unsigned(s_re3);
    m_im  = n_im ? $unsigned(-s_im3) : $unsigned(s_im3);
    nn_re = NNW'(m_re) << F;
    nn_im = NNW'(m_im) << F;
    // quotient of 2^W or more is flagged here; the final stage saturates it instead of using the divider result
    pov = (XW'(nn_re) >= (XW'(den3) << W)) || (XW'(nn_im) >= (XW'(den3) << W));
  end

  // divider stages: index 0 is the stage-4 register, index W the last step
  logic          dv    [0:W];
  logic          isdiv [0:W];
  logic          dz    [0:W];
  logic          po    [0:W];
  logic          ng_re [0:W];
  logic          ng_im [0:W];
  logic [DW-1:0] den   [0:W];
  logic [DW-1:0] rm_re [0:W];
  logic [DW-1:0] rm_im [0:W];
  logic [W-1:0]  lo_re [0:W];
  logic [W-1:0]  lo_im [0:W];
  logic [W-1:0]  q_re  [0:W];
  logic [W-1:0]  q_im  [0:W];
  logic [W-1:0]  fr_re [0:W];
  logic [W-1:0]  fr_im [0:W];
  logic          fr_eq [0:W];
  logic          fr_ov [0:W];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= v3;
    end
    if (adv) begin
      isdiv[0] <= (op3 == OP_DIV);
      dz[0]    <= (den3 == '0);
      po[0]    <= pov;
      ng_re[0] <= n_re;
      ng_im[0] <= n_im;
      den[0]   <= den3;
      rm_re[0] <= DW'(nn_re >> W);
      rm_im[0] <= DW'(nn_im >> W);
      lo_re[0] <= nn_re[W-1:0];
      lo_im[0] <= nn_im[W-1:0];
      q_re[0]  <= '0;
      q_im[0]  <= '0;
      fr_re[0] <= f_re;
      fr_im[0] <= f_im;
      fr_eq[0] <= f_eq;
      fr_ov[0] <= f_ov;
    end
  end

  for (genvar j = 0; j < W; j++) begin : g_div
    localparam int K = W - 1 - j;
    logic [DW:0]   t_re, t_im;
    logic          ge_re, ge_im;
    logic [DW-1:0] r_re_next, r_im_next;
    logic [W-1:0]  q_re_next, q_im_next;

    always_comb begin
      t_re      = {rm_re[j], lo_re[j][K]};
      t_im      = {rm_im[j], lo_im[j][K]};
      ge_re     = (t_re >= {1'b0, den[j]});
      ge_im     = (t_im >= {1'b0, den[j]});
      r_re_next = ge_re ? DW'(t_re - {1'b0, den[j]}) : DW'(t_re);
      r_im_next = ge_im ? DW'(t_im - {1'b0, den[j]}) : DW'(t_im);
      q_re_next = q_re[j];
      q_im_next = q_im[j];
      q_re_next[K] = ge_re;
      q_im_next[K] = ge_im;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1] <= 1'b0;
      end else if (adv) begin
        dv[j+1] <= dv[j];
      end
      if (adv) begin
        isdiv[j+1] <= isdiv[j];
        dz[j+1]    <= dz[j];
        po[j+1]    <= po[j];
        ng_re[j+1] <= ng_re[j];
        ng_im[j+1] <= ng_im[j];
        den[j+1]   <= den[j];
        rm_re[j+1] <= r_re_next;
        rm_im[j+1] <= r_im_next;
        lo_re[j+1] <= lo_re[j];
        lo_im[j+1] <= lo_im[j];
        q_re[j+1]  <= q_re_next;
        q_im[j+1]  <= q_im_next;
        fr_re[j+1] <= fr_re[j];
        fr_im[j+1] <= fr_im[j];
        fr_eq[j+1] <= fr_eq[j];
        fr_ov[j+1] <= fr_ov[j];
      end
    end
  end

  // final stage: sign and saturate the quotient, output register
  logic [W-1:0] res_re_next, res_im_next;
  logic         eq_next, dz_next, ov_next;
  logic         ov_re, ov_im;
  logic [W-1:0] qr, qi;

  always_comb begin
    qr    = q_re[W];
    qi    = q_im[W];
    ov_re = 1'b0;
    ov_im = 1'b0;
    res_re_next = fr_re[W];
    res_im_next = fr_im[W];
    eq_next     = fr_eq[W];
    dz_next     = 1'b0;
    ov_next     = fr_ov[W];
    if (isdiv[W]) begin
      eq_next = 1'b0;
      if (dz[W]) begin
        res_re_next = '0;
        res_im_next = '0;
        dz_next     = 1'b1;
        ov_next     = 1'b0;
      end else begin
        if (ng_re[W]) begin
          ov_re       = po[W] || (qr > MINV);
          res_re_next = ov_re ? MINV : W'(-qr);
        end else begin
          ov_re       = po[W] || qr[W-1];
          res_re_next = ov_re ? MAXV : qr;
        end
        if (ng_im[W]) begin
          ov_im       = po[W] || (qi > MINV);
          res_im_next = ov_im ? MINV : W'(-qi);
        end else begin
          ov_im       = po[W] || qi[W-1];
          res_im_next = ov_im ? MAXV : qi;
        end
        ov_next = ov_re | ov_im;
      end
    end
  end

  logic [W-1:0] ores_re, ores_im;
  logic         oeq, odz, oov;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovld <= 1'b0;
    end else if (adv) begin
      ovld <= dv[W];
    end
    if (adv) begin
      ores_re <= res_re_next;
      ores_im <= res_im_next;
      oeq     <= eq_next;
      odz     <= dz_next;
      oov     <= ov_next;
    end
  end

  assign rsp.valid      = ovld;
  assign rsp.res_re     = ores_re;
  assign rsp.res_im     = ores_im;
  assign rsp.is_equal   = oeq;
  assign rsp.div_zero   = odz;
  assign rsp.overflowed = oov;

endmodule

@@ design/cau_checker.sv @@
// cau_checker: port-level checks of complex_arith_unit, attached by bind
// depends on the top level's channel interfaces
module cau_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_ready,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic [DATA_WIDTH-1:0] res_re,
  input logic [DATA_WIDTH-1:0] res_im,
  input logic                  is_equal,
  input logic                  div_zero,
  input logic                  overflowed
);

  // a result waiting for a transfer stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

  // stalls come only from the output side
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("input stalled with empty output");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && div_zero |-> res_re == '0 && res_im == '0 && !overflowed && !is_equal)
    else $error("zero divisor result not cleared");

  a_eq_alone: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && is_equal |-> res_re == '0 && res_im == '0 && !overflowed)
    else $error("compare result carries data or overflow");

endmodule

bind complex_arith_unit cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (
  .clk        (clk),
  .rst        (rst),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .res_re     (rsp.res_re),
  .res_im     (rsp.res_im),
  .is_equal   (rsp.is_equal),
  .div_zero   (rsp.div_zero),
  .overflowed (rsp.overflowed)
);
